FILE: src/csd_pkg.sv
// Shared types and constants for the separable 5x5 reduce filter.
// No dependencies; every other source file depends on this package.
`default_nettype none
package csd_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 16;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIX_BITS      = 8;
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int MODE_BITS     = 2;
    localparam int ROW_BITS      = 13;
    localparam int COL_BITS      = 13;
    localparam int CFG_IDX_BITS  = 3;
    localparam int NTAPS         = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF0,
        REG_COEF1,
        REG_COEF2,
        REG_COEF3,
        REG_COEF4,
        REG_WIDTH,
        REG_HEIGHT,
        REG_MODE
    } cfg_reg_t;

    // one classified scan position, handed from front to back
    typedef struct packed {
        logic [PIX_BITS-1:0] pix;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                col_ok;
        logic                row_wr;
        logic                emit;
        logic                last;
    } csd_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_VERT,
        B_WRITE,
        B_HORZ,
        B_OUT
    } back_state_t;
endpackage
`default_nettype wire

FILE: src/csd_if.sv
// Stream interfaces for pixel input and filtered output.
// Depends on csd_pkg for the pixel width.
`default_nettype none
interface csd_pix_in_if;
    logic                         valid;
    logic                         ready;
    logic [csd_pkg::PIX_BITS-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface csd_pix_out_if;
    logic                         valid;
    logic                         ready;
    logic [csd_pkg::PIX_BITS-1:0] out_pixel;
    logic                         frame_done;
    modport source (output valid, output out_pixel, output frame_done, input ready);
    modport sink (input valid, input out_pixel, input frame_done, output ready);
endinterface
`default_nettype wire

FILE: src/conv5x5_separable_decimate.sv
// Separable 5x5 smoothing filter with optional decimation by two.
// The back end sequences every tap through one multiplier and one line store
// port, so it takes a new item from the queue only after it is through with
// the last one.
// Reset: scan position, column sums and control clear; registers take defaults.
// Depends on csd_pkg, csd_if, csd_front, csd_fifo and csd_back.
`default_nettype none
module conv5x5_separable_decimate #(
    parameter int MAX_WIDTH = csd_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = csd_pkg::COEF_BITS_DEF,
    localparam int CFG_W    = (COEF_BITS > csd_pkg::HEIGHT_BITS) ? COEF_BITS
                                                                 : csd_pkg::HEIGHT_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    csd_pix_in_if.sink                               pix_in,
    csd_pix_out_if.source                            pix_out,
    input  wire logic                                cfg_we,
    input  wire logic [csd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]                    cfg_data
);
    import csd_pkg::*;

    // Q2.x unity for the default kernel 1 4 6 4 1 over 16
    localparam int COEF_ONE = 1 << (COEF_BITS - 2);

    logic [NTAPS-1:0][COEF_BITS-1:0] coef_reg;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [MODE_BITS-1:0]   mode_reg;

    logic [COL_BITS-1:0] width_c;
    logic [ROW_BITS-1:0] height_c;
    logic       push, q_full, q_valid, q_pop;
    csd_item_t  f_item, q_item;

    // register writes; the index decodes fully over the eight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= COEF_BITS'(COEF_ONE / 16);
            coef_reg[1] <= COEF_BITS'(COEF_ONE * 4 / 16);
            coef_reg[2] <= COEF_BITS'(COEF_ONE * 6 / 16);
            coef_reg[3] <= COEF_BITS'(COEF_ONE * 4 / 16);
            coef_reg[4] <= COEF_BITS'(COEF_ONE / 16);
            width_reg   <= WIDTH_BITS'(1024);
            height_reg  <= HEIGHT_BITS'(1024);
            mode_reg    <= MODE_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEF0:  coef_reg[0] <= cfg_data[COEF_BITS-1:0];
                REG_COEF1:  coef_reg[1] <= cfg_data[COEF_BITS-1:0];
                REG_COEF2:  coef_reg[2] <= cfg_data[COEF_BITS-1:0];
                REG_COEF3:  coef_reg[3] <= cfg_data[COEF_BITS-1:0];
                REG_COEF4:  coef_reg[4] <= cfg_data[COEF_BITS-1:0];
                REG_WIDTH:  width_reg   <= cfg_data[WIDTH_BITS-1:0];
                REG_HEIGHT: height_reg  <= cfg_data[HEIGHT_BITS-1:0];
                REG_MODE:   mode_reg    <= cfg_data[MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp sizes to the supported range: zero counts as one
    always_comb
    begin
        if (width_reg == '0)
            width_c = COL_BITS'(1);
        else if (COL_BITS'(width_reg) > COL_BITS'(MAX_WIDTH))
            width_c = COL_BITS'(MAX_WIDTH);
        else
            width_c = COL_BITS'(width_reg);
        if (height_reg == '0)
            height_c = ROW_BITS'(1);
        else if (ROW_BITS'(height_reg) > ROW_BITS'(MAX_HEIGHT))
            height_c = ROW_BITS'(MAX_HEIGHT);
        else
            height_c = ROW_BITS'(height_reg);
    end

    // front: scan position and classification
    csd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .pix      (pix_in.pixel),
        .width    (width_c),
        .height   (height_c),
        .decimate (mode_reg[0]),
        .q_full   (q_full),
        .push     (push),
        .item     (f_item)
    );

    // short queue decouples the two halves
    csd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (f_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_item),
        .valid (q_valid)
    );

    // back: line store, two MAC passes, output register
    csd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .coef        (coef_reg),
        .width       (width_c),
        .height      (height_c),
        .zero_border (mode_reg[1]),
        .out_valid   (pix_out.valid),
        .out_ready   (pix_out.ready),
        .out_pixel   (pix_out.out_pixel),
        .frame_done  (pix_out.frame_done)
    );
endmodule
`default_nettype wire

FILE: src/csd_front.sv
// Front end: scan counters and classification of each accepted pixel.
// Depends on csd_pkg.
`default_nettype none
module csd_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [csd_pkg::PIX_BITS-1:0]    pix,
    input  wire logic [csd_pkg::COL_BITS-1:0]    width,
    input  wire logic [csd_pkg::ROW_BITS-1:0]    height,
    input  wire logic                            decimate,
    input  wire logic                            q_full,
    output logic                                 push,
    output csd_pkg::csd_item_t                   item
);
    import csd_pkg::*;

    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS:0]   h_p1, row_c, i_pos, li;
    logic [COL_BITS:0]   w_p1, col_c, j_pos, lj;
    logic                emit;

    always_comb
    begin
        h_p1  = {1'b0, height} + 1'b1;
        w_p1  = {1'b0, width} + 1'b1;
        row_c = ({1'b0, row_reg} > h_p1) ? h_p1 : {1'b0, row_reg};
        col_c = ({1'b0, col_reg} > w_p1) ? w_p1 : {1'b0, col_reg};
        i_pos = row_c - 2'd2;
        j_pos = col_c - 2'd2;
        li    = {1'b0, height} - 1'b1;
        lj    = {1'b0, width} - 1'b1;
        if (decimate)
        begin
            li[0] = 1'b0;
            lj[0] = 1'b0;
        end
        emit = (row_c >= 2) && (col_c >= 2) && (!decimate || !(i_pos[0] | j_pos[0]));

        item.pix    = pix;
        item.row    = row_c[ROW_BITS-1:0];
        item.col    = col_c[COL_BITS-1:0];
        item.col_ok = col_c < {1'b0, width};
        item.row_wr = row_c < {1'b0, height};
        item.emit   = emit;
        item.last   = emit && (i_pos == li) && (j_pos == lj);

        in_ready = !q_full;
        push     = in_valid && !q_full;

        row_next = row_c[ROW_BITS-1:0];
        col_next = col_c[COL_BITS-1:0] + 1'b1;
        if (col_c == w_p1)
        begin
            col_next = '0;
            row_next = (row_c == h_p1) ? '0 : row_c[ROW_BITS-1:0] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end
endmodule
`default_nettype wire

FILE: src/csd_fifo.sv
// Two-entry queue of classified items between front and back.
// Depends on csd_pkg.
`default_nettype none
module csd_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  csd_pkg::csd_item_t      din,
    output logic                    full,
    input  wire logic               pop,
    output csd_pkg::csd_item_t      dout,
    output logic                    valid
);
    import csd_pkg::*;

    csd_item_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg[1];
    assign valid = cnt_reg != 2'd0;
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: src/csd_back.sv
// Back end: line store, vertical and horizontal MAC passes on one shared
// multiplier, saturation and the output register. Depends on csd_pkg.
`default_nettype none
module csd_back #(
    parameter int MAX_WIDTH = csd_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = csd_pkg::COEF_BITS_DEF
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           q_valid,
    input  csd_pkg::csd_item_t                                  q_item,
    output logic                                                q_pop,
    input  wire logic [csd_pkg::NTAPS-1:0][COEF_BITS-1:0]       coef,
    input  wire logic [csd_pkg::COL_BITS-1:0]                   width,
    input  wire logic [csd_pkg::ROW_BITS-1:0]                   height,
    input  wire logic                                           zero_border,
    output logic                                                out_valid,
    input  wire logic                                           out_ready,
    output logic [csd_pkg::PIX_BITS-1:0]                        out_pixel,
    output logic                                                frame_done
);
    import csd_pkg::*;

    localparam int AW    = $clog2(4 * MAX_WIDTH);
    localparam int CS_W  = COEF_BITS + 12;
    localparam int PW    = CS_W + COEF_BITS;
    localparam int AC_W  = 2 * COEF_BITS + 15;
    localparam int SHIFT = 2 * (COEF_BITS - 2);
    localparam int QW    = AC_W - SHIFT;

    logic [PIX_BITS-1:0] store [4 * MAX_WIDTH];
    logic [PIX_BITS-1:0] rd_reg;

    back_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    csd_item_t   item_reg;
    logic signed [AC_W-1:0] acc_reg, acc_next;
    logic signed [CS_W-1:0] colsum_reg [NTAPS];
    logic        pend_skip_reg, pend_pix_reg;
    logic [2:0]  pend_k_reg;
    logic        out_valid_reg;
    logic [PIX_BITS-1:0] out_pixel_reg;
    logic        frame_done_reg;

    // control
    logic        mem_we, mem_rd, mac_en, acc_clr, shift_en, load_out, take;
    logic [AW-1:0] mem_addr;
    logic        v_skip, v_pix, h_skip;
    logic signed [ROW_BITS+1:0] r_pos, h_m1, row_s;
    logic signed [COL_BITS+1:0] c_pos, w_m1, col_s, idx_s;
    logic [1:0]  slot;
    logic [2:0]  h_idx;
    logic signed [CS_W-1:0]      mul_a;
    logic signed [COEF_BITS-1:0] mul_b;
    logic signed [PW-1:0]        prod;
    logic [QW-1:0]               q_wide;
    logic [PIX_BITS-1:0]         q_sat;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                step_next = 3'd0;
                if (q_valid)
                    state_next = B_VERT;
            end
            B_VERT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd5)
                    state_next = B_WRITE;
            end
            B_WRITE:
            begin
                step_next  = 3'd0;
                state_next = item_reg.emit ? B_HORZ : B_IDLE;
            end
            B_HORZ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!out_valid_reg)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        row_s  = $signed({2'b00, item_reg.row});
        col_s  = $signed({2'b00, item_reg.col});
        h_m1   = (ROW_BITS+2)'($signed({2'b00, height}) - 1);
        w_m1   = (COL_BITS+2)'($signed({2'b00, width}) - 1);
        // vertical tap position for the read issued this step
        r_pos  = (ROW_BITS+2)'(row_s - 4 + $signed({{(ROW_BITS-1){1'b0}}, step_reg}));
        v_skip = !item_reg.col_ok;
        if (r_pos < 0)
        begin
            v_skip = v_skip || zero_border;
            r_pos  = '0;
        end
        else if (r_pos > h_m1)
        begin
            v_skip = v_skip || zero_border;
            r_pos  = h_m1;
        end
        v_pix = r_pos == row_s;
        slot  = r_pos[1:0];

        // horizontal tap position
        c_pos  = (COL_BITS+2)'(col_s - 4 + $signed({{(COL_BITS-1){1'b0}}, step_reg}));
        h_skip = 1'b0;
        if (c_pos < 0)
        begin
            h_skip = zero_border;
            c_pos  = '0;
        end
        else if (c_pos > w_m1)
        begin
            h_skip = zero_border;
            c_pos  = w_m1;
        end
        idx_s = (COL_BITS+2)'(c_pos - col_s + 4);
        h_idx = idx_s[2:0];

        take     = 1'b0;
        mem_we   = 1'b0;
        mem_rd   = 1'b0;
        mac_en   = 1'b0;
        acc_clr  = 1'b0;
        shift_en = 1'b0;
        load_out = 1'b0;
        mem_addr = AW'(slot) * AW'(MAX_WIDTH) + AW'(item_reg.col);
        mul_a    = $signed({{(CS_W-PIX_BITS){1'b0}},
                            (pend_pix_reg ? item_reg.pix : rd_reg)});
        mul_b    = $signed(coef[pend_k_reg]);
        unique case (state_reg)
            B_IDLE:
            begin
                take    = q_valid;
                acc_clr = 1'b1;
            end
            B_VERT:
            begin
                mem_rd = step_reg != 3'd5;
                mac_en = (step_reg != 3'd0) && !pend_skip_reg;
            end
            B_WRITE:
            begin
                // the new pixel goes to the slot of its own row
                mem_addr = AW'(item_reg.row[1:0]) * AW'(MAX_WIDTH) + AW'(item_reg.col);
                mem_we   = item_reg.row_wr && item_reg.col_ok;
                shift_en = 1'b1;
                acc_clr  = 1'b1;
            end
            B_HORZ:
            begin
                mul_a  = colsum_reg[h_idx];
                mul_b  = $signed(coef[step_reg]);
                mac_en = !h_skip;
            end
            B_OUT:
            begin
                load_out = !out_valid_reg;
            end
            default: ;
        endcase

        prod     = mul_a * mul_b;
        acc_next = acc_reg;
        if (acc_clr)
            acc_next = '0;
        else if (mac_en)
            acc_next = acc_reg + {{(AC_W-PW){prod[PW-1]}}, prod};

        // truncate, then clamp to the pixel range
        q_wide = acc_reg[AC_W-1:SHIFT];
        if (acc_reg[AC_W-1])
            q_sat = '0;
        else if (|q_wide[QW-1:PIX_BITS])
            q_sat = '1;
        else
            q_sat = q_wide[PIX_BITS-1:0];
    end

    assign q_pop      = take;
    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign frame_done = frame_done_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_addr] <= item_reg.pix;
        else if (mem_rd)
            rd_reg <= store[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= q_item;
        if (state_reg == B_VERT)
        begin
            pend_skip_reg <= v_skip;
            pend_pix_reg  <= v_pix;
            pend_k_reg    <= step_reg;
        end
        acc_reg <= acc_next;
        if (load_out)
        begin
            out_pixel_reg  <= q_sat;
            frame_done_reg <= item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < NTAPS; n++)
                colsum_reg[n] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (shift_en)
            begin
                for (int n = 0; n < NTAPS - 1; n++)
                    colsum_reg[n] <= colsum_reg[n + 1];
                colsum_reg[NTAPS-1] <= acc_reg[CS_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/csd_checker.sv
// Port-level checks on the output channel of the reduce filter, bound to
// the top level. Depends on csd_pkg and conv5x5_separable_decimate.
`default_nettype none
module csd_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [csd_pkg::PIX_BITS-1:0]   out_pixel,
    input wire logic                           out_last
);
    // hold the result until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before handshake");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_last))
        else $error("output payload changed while stalled");

    // the output register refills only from empty
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("output reloaded in the cycle it was taken");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid after reset");
endmodule

bind conv5x5_separable_decimate csd_checker u_csd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_pixel (pix_out.out_pixel),
    .out_last  (pix_out.frame_done)
);
`default_nettype wire
